// ===== rtl/rhp_pkg.sv =====
// Package for the response header parser: beat types, codes and prefix tables.
`timescale 1ns / 1ps
`default_nettype none

package rhp_pkg;

    // Sizes of the pending table and of the length header value.
    localparam int PENDING_SLOTS = 8;
    localparam int SLOT_W        = $clog2(PENDING_SLOTS);
    localparam int LENGTH_BITS   = 32;
    localparam int ACC_W         = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam int PROD_W        = ACC_W + 4;

    // Prefix lengths and the bytes that end or poison a line.
    localparam int RESP_PLEN     = 16;
    localparam int LEN_PLEN      = 8;
    localparam int POS_W         = 5;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_I   = 8'h49;
    localparam logic [7:0] CH_L   = 8'h4C;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    // Request kinds.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_SLOT = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_MATCHED = 2'd0,
        ST_BAD     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FATAL   = 2'd3
    } status_t;

    // Message phase.
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_FATAL  = 3'b100
    } phase_t;

    // Which header prefix the current line may still carry.
    typedef enum logic [3:0] {
        PK_BOTH = 4'b0001,
        PK_RESP = 4'b0010,
        PK_LEN  = 4'b0100,
        PK_NONE = 4'b1000
    } prefix_t;

    // Input beat.
    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [2:0]  slot_index;
        logic [31:0] slot_id;
        logic        slot_valid;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  selected_slot;
        logic [31:0] response_id;
        logic [31:0] body_length;
    } out_beat_t;

    // Write to the pending table.
    typedef struct packed {
        logic              en;
        logic [2:0]        idx;
        logic [31:0]       id;
        logic              valid;
    } slot_wr_t;

    // Lowest valid slot whose id equals the current response id.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } match_t;

    // Byte of "In response to: " at a position.
    function automatic logic [7:0] resp_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h49; // I
            4'd1:    c = 8'h6E; // n
            4'd2:    c = 8'h20;
            4'd3:    c = 8'h72; // r
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h73; // s
            4'd6:    c = 8'h70; // p
            4'd7:    c = 8'h6F; // o
            4'd8:    c = 8'h6E; // n
            4'd9:    c = 8'h73; // s
            4'd10:   c = 8'h65; // e
            4'd11:   c = 8'h20;
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h6F; // o
            4'd14:   c = 8'h3A; // :
            4'd15:   c = 8'h20;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // Byte of "Length: " at a position.
    function automatic logic [7:0] len_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h4C; // L
            3'd1:    c = 8'h65; // e
            3'd2:    c = 8'h6E; // n
            3'd3:    c = 8'h67; // g
            3'd4:    c = 8'h74; // t
            3'd5:    c = 8'h68; // h
            3'd6:    c = 8'h3A; // :
            3'd7:    c = 8'h20;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rhp_in_reg.sv =====
// Input register stage of the response header parser.
`timescale 1ns / 1ps
`default_nettype none

module rhp_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire rhp_pkg::in_beat_t req_beat,
    input  wire logic             fire,
    output logic                  item_valid,
    output rhp_pkg::in_beat_t     item_beat
);

    logic              vld_reg;
    rhp_pkg::in_beat_t beat_reg;

    // The held beat blocks the port until the parser takes it.
    assign req_stall  = vld_reg && !fire;
    assign item_valid = vld_reg;
    assign item_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            beat_reg <= req_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rhp_slot_table.sv =====
// Pending request table with a parallel id compare.
`timescale 1ns / 1ps
`default_nettype none

module rhp_slot_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rhp_pkg::slot_wr_t wr,
    input  wire logic [31:0]       resp_id,
    output rhp_pkg::match_t        match
);

    logic [31:0]                        ids_reg [rhp_pkg::PENDING_SLOTS];
    logic [rhp_pkg::PENDING_SLOTS-1:0]  valid_reg;
    logic                               wr_hit;

    // Writes past the end of the table are dropped.
    assign wr_hit = wr.en && (32'(wr.idx) < 32'(rhp_pkg::PENDING_SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_hit)
        begin
            valid_reg[wr.idx[rhp_pkg::SLOT_W-1:0]] <= wr.valid;
        end
    end

    // The id store has no reset; an id is only read under its valid bit.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            ids_reg[wr.idx[rhp_pkg::SLOT_W-1:0]] <= wr.id;
        end
    end

    // Priority pick of the lowest matching slot.
    always_comb
    begin
        match.hit  = 1'b0;
        match.slot = '0;
        for (int i = rhp_pkg::PENDING_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (ids_reg[i] == resp_id))
            begin
                match.hit  = 1'b1;
                match.slot = rhp_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rhp_parser.sv =====
// Header line parser, body counter and result forming.
`timescale 1ns / 1ps
`default_nettype none

module rhp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire rhp_pkg::in_beat_t  beat,
    input  wire rhp_pkg::match_t    match,
    output logic [31:0]             resp_id,
    output logic                    res_valid,
    output rhp_pkg::out_beat_t      res_beat
);

    rhp_pkg::phase_t                 phase_reg,  phase_next;
    logic [rhp_pkg::POS_W-1:0]       pos_reg,    pos_next;
    rhp_pkg::prefix_t                kind_reg,   kind_next;
    logic                            ended_reg,  ended_next;
    logic [rhp_pkg::ACC_W-1:0]       acc_reg,    acc_next;
    logic                            canon_reg,  canon_next;
    logic                            bad_reg,    bad_next;
    logic [31:0]                     resp_reg,   resp_next;
    logic [rhp_pkg::LENGTH_BITS-1:0] len_reg,    len_next;
    logic [rhp_pkg::LENGTH_BITS-1:0] rem_reg,    rem_next;

    logic [7:0]                      c;
    logic                            is_digit;
    logic [3:0]                      d;
    logic [rhp_pkg::PROD_W-1:0]      acc_wide;
    logic [rhp_pkg::PROD_W-1:0]      prod;
    logic                            len_ovf;
    logic [63:0]                     len_wide;
    rhp_pkg::out_beat_t              fin_beat;
    rhp_pkg::status_t                fin_status;

    assign resp_id = resp_reg;

    // Decimal step: accumulator times ten plus the digit.
    assign c        = beat.data_byte;
    assign is_digit = (c >= rhp_pkg::CH_0) && (c <= rhp_pkg::CH_9);
    assign d        = 4'(c - rhp_pkg::CH_0);
    assign acc_wide = rhp_pkg::PROD_W'(acc_reg);
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + rhp_pkg::PROD_W'(d);
    assign len_ovf  = (prod >> rhp_pkg::LENGTH_BITS) != '0;
    assign len_wide = 64'(len_reg);

    // Result of a completed message.
    always_comb
    begin
        if (bad_reg)
        begin
            fin_status = rhp_pkg::ST_BAD;
        end
        else if (match.hit)
        begin
            fin_status = rhp_pkg::ST_MATCHED;
        end
        else
        begin
            fin_status = rhp_pkg::ST_IGNORED;
        end
        fin_beat.status        = fin_status;
        fin_beat.selected_slot = (!bad_reg && match.hit) ? 3'(match.slot) : 3'd0;
        fin_beat.response_id   = resp_reg;
        fin_beat.body_length   = len_wide[31:0];
    end

    // Next state for one message byte.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        ended_next = ended_reg;
        acc_next   = acc_reg;
        canon_next = canon_reg;
        bad_next   = bad_reg;
        resp_next  = resp_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        res_valid  = 1'b0;
        res_beat   = fin_beat;

        if (fire && (beat.req_type == rhp_pkg::REQ_BYTE))
        begin
            case (phase_reg)
                rhp_pkg::PH_FATAL:
                begin
                    // Sticky: bytes are dropped until reset.
                end
                rhp_pkg::PH_BODY:
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                    if ((rem_reg == '0) || (rem_reg == rhp_pkg::LENGTH_BITS'(1)))
                    begin
                        res_valid  = 1'b1;
                        bad_next   = 1'b0;
                        len_next   = '0;
                        rem_next   = '0;
                        phase_next = rhp_pkg::PH_HEADER;
                    end
                end
                rhp_pkg::PH_HEADER:
                begin
                    if (c == rhp_pkg::CH_NL)
                    begin
                        // End of line: start the next one afresh.
                        pos_next   = '0;
                        kind_next  = rhp_pkg::PK_BOTH;
                        ended_next = 1'b0;
                        acc_next   = '0;
                        canon_next = 1'b1;
                        if (pos_reg == '0)
                        begin
                            // Empty line opens the body.
                            phase_next = rhp_pkg::PH_BODY;
                            rem_next   = len_reg;
                            if (len_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                bad_next   = 1'b0;
                                phase_next = rhp_pkg::PH_HEADER;
                            end
                        end
                        else if ((kind_reg == rhp_pkg::PK_RESP) &&
                                 (pos_reg >= rhp_pkg::POS_W'(rhp_pkg::RESP_PLEN)))
                        begin
                            resp_next = acc_reg[31:0];
                        end
                        else if ((kind_reg == rhp_pkg::PK_LEN) &&
                                 (pos_reg >= rhp_pkg::POS_W'(rhp_pkg::LEN_PLEN)))
                        begin
                            if (!canon_reg ||
                                (pos_reg == rhp_pkg::POS_W'(rhp_pkg::LEN_PLEN)))
                            begin
                                phase_next            = rhp_pkg::PH_FATAL;
                                res_valid             = 1'b1;
                                res_beat.status       = rhp_pkg::ST_FATAL;
                                res_beat.selected_slot = 3'd0;
                                res_beat.response_id  = resp_reg;
                                res_beat.body_length  = 32'd0;
                            end
                            else
                            begin
                                len_next = acc_reg[rhp_pkg::LENGTH_BITS-1:0];
                            end
                        end
                    end
                    else if (ended_reg)
                    begin
                        // Text already cut short by a NUL.
                    end
                    else if (c == rhp_pkg::CH_NUL)
                    begin
                        bad_next   = 1'b1;
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        // Ordinary header character.
                        case (kind_reg)
                            rhp_pkg::PK_BOTH:
                            begin
                                if (c == rhp_pkg::CH_I)
                                begin
                                    kind_next = rhp_pkg::PK_RESP;
                                end
                                else if (c == rhp_pkg::CH_L)
                                begin
                                    kind_next = rhp_pkg::PK_LEN;
                                end
                                else
                                begin
                                    kind_next = rhp_pkg::PK_NONE;
                                end
                            end
                            rhp_pkg::PK_RESP:
                            begin
                                if (pos_reg < rhp_pkg::POS_W'(rhp_pkg::RESP_PLEN))
                                begin
                                    if (c != rhp_pkg::resp_char(pos_reg[3:0]))
                                    begin
                                        kind_next = rhp_pkg::PK_NONE;
                                    end
                                end
                                else if (is_digit)
                                begin
                                    acc_next = rhp_pkg::ACC_W'(prod[31:0]);
                                end
                                else
                                begin
                                    resp_next = acc_reg[31:0];
                                    kind_next = rhp_pkg::PK_NONE;
                                end
                            end
                            rhp_pkg::PK_LEN:
                            begin
                                if (pos_reg < rhp_pkg::POS_W'(rhp_pkg::LEN_PLEN))
                                begin
                                    if (c != rhp_pkg::len_char(pos_reg[2:0]))
                                    begin
                                        kind_next = rhp_pkg::PK_NONE;
                                    end
                                end
                                else if (canon_reg)
                                begin
                                    if (!is_digit || len_ovf ||
                                        ((pos_reg > rhp_pkg::POS_W'(rhp_pkg::LEN_PLEN)) &&
                                         (acc_reg == '0)))
                                    begin
                                        canon_next = 1'b0;
                                    end
                                    else
                                    begin
                                        acc_next = rhp_pkg::ACC_W'(prod);
                                    end
                                end
                            end
                            default:
                            begin
                                // No prefix: the line is skipped.
                            end
                        endcase
                        if (pos_reg != '1)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = rhp_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rhp_pkg::PH_HEADER;
            pos_reg   <= '0;
            kind_reg  <= rhp_pkg::PK_BOTH;
            ended_reg <= 1'b0;
            acc_reg   <= '0;
            canon_reg <= 1'b1;
            bad_reg   <= 1'b0;
            resp_reg  <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            ended_reg <= ended_next;
            acc_reg   <= acc_next;
            canon_reg <= canon_next;
            bad_reg   <= bad_next;
            resp_reg  <= resp_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rhp_out_reg.sv =====
// Result register of the response header parser.
`timescale 1ns / 1ps
`default_nettype none

module rhp_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire rhp_pkg::out_beat_t res_beat,
    output logic                    ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rhp_pkg::out_beat_t      rsp_beat
);

    logic               vld_reg;
    rhp_pkg::out_beat_t beat_reg;

    // Room for a new result when empty or being drained this cycle.
    assign ready     = !vld_reg || !rsp_stall;
    assign rsp_valid = vld_reg;
    assign rsp_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            vld_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            beat_reg <= res_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/response_header_parser.sv =====
// Top level of the response header parser.
//
//  Channel | Valid     | Stall     | Beat
//  --------+-----------+-----------+----------------------------------------
//  request | req_valid | req_stall | req_beat: message byte or slot write
//  result  | rsp_valid | rsp_stall | rsp_beat: status, slot, id, length
//
// One beat is taken per cycle: a held beat in the input register is parsed
// in a single pass and any result lands in the output register; a result
// passes the input and then the output register before it is offered.  The
// input register only holds back while the output register is full and
// stalled.  Reset clears the parser, both valid bits and the pending valid
// bits; pending ids are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module response_header_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire rhp_pkg::in_beat_t  req_beat,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rhp_pkg::out_beat_t      rsp_beat
);

    logic               item_valid;
    rhp_pkg::in_beat_t  item_beat;
    logic               out_ready;
    logic               fire;
    rhp_pkg::slot_wr_t  slot_wr;
    rhp_pkg::match_t    match;
    logic [31:0]        resp_id;
    logic               res_valid;
    rhp_pkg::out_beat_t res_beat;

    // A held beat is consumed whenever the result side has room.
    assign fire = item_valid && out_ready;

    // Slot writes go straight to the pending table.
    assign slot_wr.en    = fire && (item_beat.req_type == rhp_pkg::REQ_SLOT);
    assign slot_wr.idx   = item_beat.slot_index;
    assign slot_wr.id    = item_beat.slot_id;
    assign slot_wr.valid = item_beat.slot_valid;

    rhp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_beat   (req_beat),
        .fire       (fire),
        .item_valid (item_valid),
        .item_beat  (item_beat)
    );

    rhp_slot_table u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (slot_wr),
        .resp_id (resp_id),
        .match   (match)
    );

    rhp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (item_beat),
        .match     (match),
        .resp_id   (resp_id),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

    rhp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_beat  (res_beat),
        .ready     (out_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

endmodule

`default_nettype wire

// ===== rtl/rhp_checker.sv =====
// Port-level checks for the response header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rhp_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_stall,
    input  wire rhp_pkg::out_beat_t rsp_beat
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
        else $error("stalled result beat changed or vanished");

    // A fatal length result carries no slot and no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.status == rhp_pkg::ST_FATAL) |->
        (rsp_beat.selected_slot == 3'd0) && (rsp_beat.body_length == 32'd0))
        else $error("fatal result with a slot or length");

    // Only a match names a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.selected_slot != 3'd0) |->
        (rsp_beat.status == rhp_pkg::ST_MATCHED))
        else $error("slot given on an unmatched result");

    // After a fatal result nothing follows at once: the block is stuck.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && (rsp_beat.status == rhp_pkg::ST_FATAL) |=>
        !rsp_valid)
        else $error("result after a fatal length header");

endmodule

bind response_header_parser rhp_checker u_rhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_beat  (rsp_beat)
);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the response header parser: directed and random message streams, checked per beat.
`timescale 1ns / 1ps

module tb;
    import rhp_pkg::*;

    // Header prefixes and the widest length that the block accepts.
    localparam string RESP_TXT = "In response to: ";
    localparam string LEN_TXT  = "Length: ";
    localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS);

    // Tracks the parser state beat by beat and holds the replies still owed.
    class header_replies;
        phase_t      msg_phase;
        logic [4:0]  line_pos;
        prefix_t     line_prefix;
        bit          line_done;
        logic [63:0] digits;
        bit          len_ok;
        bit          msg_bad;
        logic [31:0] reply_id;
        logic [31:0] msg_length;
        logic [31:0] body_left;
        logic [31:0] slot_ids [PENDING_SLOTS];
        bit          slot_live [PENDING_SLOTS];
        out_beat_t   replies_due [$];
        int          errors;

        function new();
            msg_phase  = PH_HEADER;
            msg_bad    = 1'b0;
            reply_id   = '0;
            msg_length = '0;
            body_left  = '0;
            errors     = 0;
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
                slot_ids[i]  = '0;
            end
            start_line();
        endfunction

        function void start_line();
            line_pos    = '0;
            line_prefix = PK_BOTH;
            line_done   = 1'b0;
            digits      = '0;
            len_ok      = 1'b1;
        endfunction

        // End of a message: look up the lowest pending slot with this id.
        function void close_message();
            out_beat_t r;
            r.status        = ST_IGNORED;
            r.selected_slot = '0;
            if (msg_bad)
            begin
                r.status = ST_BAD;
            end
            else
            begin
                for (int i = PENDING_SLOTS - 1; i >= 0; i--)
                begin
                    if (slot_live[i] && slot_ids[i] == reply_id)
                    begin
                        r.status        = ST_MATCHED;
                        r.selected_slot = 3'(i);
                    end
                end
            end
            r.response_id = reply_id;
            r.body_length = msg_length;
            replies_due.push_back(r);
            msg_bad    = 1'b0;
            msg_length = '0;
            body_left  = '0;
            msg_phase  = PH_HEADER;
        endfunction

        // A newline in the header phase: empty line, id header or length header.
        function void end_line();
            out_beat_t r;
            if (line_pos == 0)
            begin
                start_line();
                msg_phase = PH_BODY;
                body_left = msg_length;
                if (body_left == 0)
                    close_message();
            end
            else
            begin
                if (line_prefix == PK_RESP && line_pos >= RESP_PLEN)
                begin
                    reply_id = digits[31:0];
                end
                else if (line_prefix == PK_LEN && line_pos >= LEN_PLEN)
                begin
                    if (!len_ok || line_pos == LEN_PLEN)
                    begin
                        msg_phase       = PH_FATAL;
                        r.status        = ST_FATAL;
                        r.selected_slot = '0;
                        r.response_id   = reply_id;
                        r.body_length   = '0;
                        replies_due.push_back(r);
                    end
                    else
                    begin
                        msg_length = digits[31:0];
                    end
                end
                start_line();
            end
        endfunction

        // One text byte of a header line.
        function void header_byte(logic [7:0] c);
            bit          is_digit;
            logic [63:0] d;
            is_digit = (c >= CH_0) && (c <= CH_9);
            d        = 64'(c - CH_0);
            if (line_prefix == PK_BOTH)
            begin
                if (c == CH_I)
                    line_prefix = PK_RESP;
                else if (c == CH_L)
                    line_prefix = PK_LEN;
                else
                    line_prefix = PK_NONE;
            end
            else if (line_prefix == PK_RESP)
            begin
                if (line_pos < RESP_PLEN)
                begin
                    if (c != RESP_TXT[line_pos])
                        line_prefix = PK_NONE;
                end
                else if (is_digit)
                begin
                    digits = (digits * 10 + d) & 64'hFFFF_FFFF;
                end
                else
                begin
                    reply_id    = digits[31:0];
                    line_prefix = PK_NONE;
                end
            end
            else if (line_prefix == PK_LEN)
            begin
                if (line_pos < LEN_PLEN)
                begin
                    if (c != LEN_TXT[line_pos])
                        line_prefix = PK_NONE;
                end
                else if (len_ok)
                begin
                    if (!is_digit || (line_pos > LEN_PLEN && digits == 0) ||
                        digits > (LEN_MAX - d) / 10)
                        len_ok = 1'b0;
                    else
                        digits = digits * 10 + d;
                end
            end
            if (line_pos < 5'd31)
                line_pos++;
        endfunction

        // Note an accepted request beat and queue any reply that it causes.
        function void take_beat(in_beat_t b);
            if (b.req_type == REQ_SLOT)
            begin
                if (b.slot_index < PENDING_SLOTS)
                begin
                    slot_ids[b.slot_index]  = b.slot_id;
                    slot_live[b.slot_index] = b.slot_valid;
                end
            end
            else if (msg_phase == PH_BODY)
            begin
                if (body_left > 0)
                    body_left--;
                if (body_left == 0)
                    close_message();
            end
            else if (msg_phase == PH_HEADER)
            begin
                if (b.data_byte == CH_NL)
                begin
                    end_line();
                end
                else if (!line_done)
                begin
                    if (b.data_byte == CH_NUL)
                    begin
                        msg_bad   = 1'b1;
                        line_done = 1'b1;
                    end
                    else
                    begin
                        header_byte(b.data_byte);
                    end
                end
            end
        endfunction

        function void check_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        // Compare an accepted result beat with the oldest reply owed.
        function void compare_reply(out_beat_t got);
            out_beat_t want;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: result beat %h arrived with none expected: expected nothing, got %h",
                         $time, got, got);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("selected_slot", 32'(want.selected_slot), 32'(got.selected_slot));
                check_field("response_id", want.response_id, got.response_id);
                check_field("body_length", want.body_length, got.body_length);
            end
        endfunction

        function int owed();
            return replies_due.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    in_beat_t    req_beat  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    out_beat_t   rsp_beat;

    header_replies sb = new();

    // Stimulus controls of the two sides; hold_cycles passes from the source to the sink.
    logic        src_burst = 1'b0;
    logic        snk_burst = 1'b0;
    logic        mix_slots = 1'b0;
    int          hold_cycles = 0;
    int          n_items = 0;
    logic [31:0] gen_ids [PENDING_SLOTS] = '{default: '0};

    response_header_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one request beat after a random gap and hold it until it is taken.
    task automatic put_beat(input in_beat_t b);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0)
            src_burst = !src_burst;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= b;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.take_beat(b);
        n_items++;
        @(negedge clk);
    endtask

    task automatic put_slot(input logic [2:0] idx, input logic [31:0] id, input logic live);
        in_beat_t b;
        b.req_type   = REQ_SLOT;
        b.data_byte  = 8'($urandom_range(0, 255));
        b.slot_index = idx;
        b.slot_id    = id;
        b.slot_valid = live;
        gen_ids[idx] = id;
        put_beat(b);
    endtask

    // A message byte, now and then preceded by a table write.
    task automatic put_byte(input logic [7:0] c);
        in_beat_t b;
        if (mix_slots && $urandom_range(0, 23) == 0)
            put_slot(3'($urandom_range(0, 7)),
                     ($urandom_range(0, 2) == 0) ? gen_ids[$urandom_range(0, 7)] : $urandom,
                     1'($urandom_range(0, 4) != 0));
        b.req_type   = REQ_BYTE;
        b.data_byte  = c;
        b.slot_index = 3'($urandom_range(0, 7));
        b.slot_id    = $urandom;
        b.slot_valid = 1'($urandom_range(0, 1));
        put_beat(b);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // Any byte but a newline.
    function automatic logic [7:0] odd_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_NL)
            c = 8'h0B;
        return c;
    endfunction

    // Mostly ids that sit in the table, some random and some at the ends.
    function automatic logic [31:0] pick_id();
        logic [31:0] id;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: id = gen_ids[$urandom_range(0, PENDING_SLOTS - 1)];
            6, 7:             id = $urandom;
            8:                id = 32'($urandom_range(0, 3));
            default:          id = 32'hFFFF_FFFF;
        endcase
        return id;
    endfunction

    function automatic int pick_body_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    endfunction

    // One whole message: a few header lines, the empty line and the body.
    task automatic random_message();
        int         n_lines;
        int         body_len;
        int         k;
        int         i;
        logic [7:0] c;
        body_len = 0;
        n_lines  = $urandom_range(0, 3);
        repeat (n_lines)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    put_text($sformatf("In response to: %0d\n", pick_id()));
                end
                3, 4:
                begin
                    body_len = pick_body_len();
                    put_text($sformatf("Length: %0d\n", body_len));
                end
                5:
                begin
                    // A wide length that a later line replaces.
                    put_text($sformatf("Length: %0d\n", $urandom));
                    body_len = pick_body_len();
                    put_text($sformatf("Length: %0d\n", body_len));
                end
                6:
                begin
                    // Any number of digits, perhaps followed by a stray byte.
                    put_text(RESP_TXT);
                    repeat ($urandom_range(0, 24)) put_byte(8'(CH_0 + $urandom_range(0, 9)));
                    if ($urandom_range(0, 1) == 1)
                        put_byte(odd_byte());
                    put_byte(CH_NL);
                end
                7:
                begin
                    // A junk line that can neither be empty nor carry a length.
                    c = odd_byte();
                    if (c == CH_NUL || c == CH_L)
                        c = "x";
                    put_byte(c);
                    repeat ($urandom_range(0, 11)) put_byte(odd_byte());
                    put_byte(CH_NL);
                end
                8:
                begin
                    // A prefix cut short, with one stray byte.
                    if ($urandom_range(0, 1) == 1)
                    begin
                        k = $urandom_range(1, RESP_PLEN - 1);
                        for (i = 0; i < k; i++)
                            put_byte(RESP_TXT[i]);
                    end
                    else
                    begin
                        k = $urandom_range(1, LEN_PLEN - 2);
                        for (i = 0; i < k; i++)
                            put_byte(LEN_TXT[i]);
                    end
                    put_byte(odd_byte());
                    put_byte(CH_NL);
                end
                default:
                begin
                    // A NUL after the length digits spoils the message.
                    body_len = pick_body_len();
                    put_text($sformatf("Length: %0d", body_len));
                    put_byte(CH_NUL);
                    repeat ($urandom_range(0, 3)) put_byte(odd_byte());
                    put_byte(CH_NL);
                end
            endcase
        end
        if ($urandom_range(0, 15) == 0)
            put_byte(CH_NUL);
        put_byte(CH_NL);
        repeat (body_len) put_byte(8'($urandom_range(0, 255)));
    endtask

    // Empty messages in a burst while the result side holds off for a long stretch.
    task automatic squeeze();
        logic keep;
        keep        = src_burst;
        src_burst   = 1'b1;
        hold_cycles = 60;
        repeat (12) put_byte(CH_NL);
        src_burst = keep;
    endtask

    // Result side: random stalls, then check each beat taken.
    initial
    begin : result_sink
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                wait_cycles = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                wait_cycles = snk_burst ? 0 : $urandom_range(0, 14);
            end
            if ($urandom_range(0, 39) == 0)
                snk_burst = !snk_burst;
            if (wait_cycles > 0)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            sb.compare_reply(rsp_beat);
        end
    end

    // Main sequence: reset, directed messages, random messages, fatal tail.
    initial
    begin : stimulus
        int first;
        int msgs;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Pending table: id zero, all ones, a duplicate pair and one idle entry.
        put_slot(3'd0, 32'h0000_0000, 1'b1);
        put_slot(3'd7, 32'hFFFF_FFFF, 1'b1);
        put_slot(3'd3, 32'd1234, 1'b0);
        put_slot(3'd2, 32'd77, 1'b1);
        put_slot(3'd5, 32'd77, 1'b1);
        // A bare empty line: no headers and an empty body.
        put_byte(CH_NL);
        // Largest id and a short body carrying a NUL and a newline.
        put_text("In response to: 4294967295\nLength: 3\n\nA");
        put_byte(CH_NUL);
        put_byte(CH_NL);
        // The id wraps onto 77, so the lower of the duplicates answers.
        put_text("In response to: 4294967373\n\n");
        // An idle slot never matches; a lone zero is a valid length.
        put_text("In response to: 1234\nLength: 0\n\n");
        // Digits stop at the first non-digit; no digits at all give zero.
        put_text("In response to: 77x9\n\n");
        put_text("In response to: \n\n");
        // A prefix one byte short leaves the id as it was.
        put_text("In response to:\n\n");
        // A line long enough to saturate the position count.
        put_text("In response to: 123456789012345678901234567\n\n");
        // Widest length, later replaced; near misses on both prefixes.
        put_text("Length: 4294967295\nLength: 0\nLengths\nIn respons\n\n");
        // A NUL as first byte empties the line and marks the message bad.
        put_byte(CH_NUL);
        put_text("abc\n");
        // A NUL after the length digits.
        put_text("Length: 2");
        put_byte(CH_NUL);
        put_text("zz\n\nxy");
        // A slot taken out of the table, then a longer body.
        put_slot(3'd7, 32'hFFFF_FFFF, 1'b0);
        put_text("In response to: 4294967295\nLength: 12\n\n0123456789\n\n");
        squeeze();

        // Random messages with table writes mixed in.
        mix_slots = 1'b1;
        first     = n_items;
        msgs      = 0;
        while (n_items - first < 750 || msgs < 40)
        begin
            random_message();
            msgs++;
            if (msgs == 20)
                squeeze();
        end

        // A bad length header stops parsing for good; later bytes give nothing.
        put_text($sformatf("In response to: %0d\n", pick_id()));
        case ($urandom_range(0, 4))
            0:       put_text("Length: \n");
            1:       put_text("Length: 012\n");
            2:       put_text($sformatf("Length: %0d \n", pick_body_len()));
            3:       put_text("Length: 4294967296\n");
            default: put_text("Length: 00\n");
        endcase
        repeat (24) put_byte(($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom_range(0, 255)));
        req_valid <= 1'b0;

        // Drain, then give any stray result time to show.
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Give up after a generous fixed time.
    initial
    begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rhp_pkg.sv
rtl/rhp_in_reg.sv
rtl/rhp_slot_table.sv
rtl/rhp_parser.sv
rtl/rhp_out_reg.sv
rtl/response_header_parser.sv
rtl/rhp_checker.sv
test/tb.sv
